FILE: rtl/core/kiss_dfr_pkg.sv
// ----------------------------------------------------------------------------
// kiss_dfr_pkg
// Shared constants and types for the KISS stream deframer.
// ----------------------------------------------------------------------------
package kiss_dfr_pkg;

  localparam int MAX_FRAME_DEF = 512;

  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_EOF = 2'd2;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] item_value;
    logic [8:0] byte_position;
    logic [9:0] frame_length;
    logic       overflowed;
  } kiss_dfr_res_t;

endpackage

FILE: rtl/core/kiss_stream_deframer.sv
// ----------------------------------------------------------------------------
// kiss_stream_deframer
// Strips KISS framing from a received serial byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_*): one raw byte per item, taken when in_valid is high
// and in_stall is low. Bytes before the first delimiter are dropped.
// Result channel (out_*): command byte, payload bytes with their position,
// and an end-of-frame item with length and overflow flag. Escapes, empty
// frames and bytes beyond MAX_FRAME give no result.
// Latency: with the receiver not stalling, a result appears on out_valid the
// cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall is low, set by the single
// decode step between the frame state registers and the output register.
// A two-entry output buffer sits before the result port; in_stall rises once
// both entries are full, which needs the receiver to stall while a further
// result arrives. It comes directly from a flop and drops the cycle after
// the receiver takes an item.
// Reset (rst_n low, synchronous) clears the frame state and empties the
// output buffer; the block is outside a frame after reset.
// ----------------------------------------------------------------------------
module kiss_stream_deframer import kiss_dfr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_item_value,
  output logic [8:0] out_byte_position,
  output logic [9:0] out_frame_length,
  output logic       out_overflowed
);

  logic          accept;
  logic          res_valid;
  kiss_dfr_res_t res;
  kiss_dfr_res_t out_data;
  logic          full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  kiss_dfr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  kiss_dfr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_item_kind     = out_data.item_kind;
  assign out_item_value    = out_data.item_value;
  assign out_byte_position = out_data.byte_position;
  assign out_frame_length  = out_data.frame_length;
  assign out_overflowed    = out_data.overflowed;

endmodule

FILE: rtl/core/kiss_dfr_core.sv
// ----------------------------------------------------------------------------
// kiss_dfr_core
// Frame state and per-byte decode; builds at most one result per byte.
// ----------------------------------------------------------------------------
module kiss_dfr_core import kiss_dfr_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output kiss_dfr_res_t res
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic             inside_r,  inside_nxt;
  logic             esc_r,     esc_nxt;
  logic             ovf_r,     ovf_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [7:0]       data_byte;

  always_comb begin
    inside_nxt = inside_r;
    esc_nxt    = esc_r;
    ovf_nxt    = ovf_r;
    count_nxt  = count_r;
    res_valid  = 1'b0;
    res        = '0;
    data_byte  = rx_byte;

    if (esc_r) begin
      if (rx_byte == KISS_TFEND) begin
        data_byte = KISS_FEND;
      end else if (rx_byte == KISS_TFESC) begin
        data_byte = KISS_FESC;
      end
    end

    if (rx_byte == KISS_FEND) begin
      // delimiter always opens a new frame; close out a non-empty one
      if (inside_r && (count_r != '0)) begin
        res_valid        = 1'b1;
        res.item_kind    = KIND_EOF;
        res.frame_length = 10'(count_r);
        res.overflowed   = ovf_r;
      end
      inside_nxt = 1'b1;
      esc_nxt    = 1'b0;
      count_nxt  = '0;
      ovf_nxt    = 1'b0;
    end else if (inside_r) begin
      if (!esc_r && (rx_byte == KISS_FESC)) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (count_r < CNT_W'(MAX_FRAME)) begin
          res_valid         = 1'b1;
          res.item_kind     = (count_r == '0) ? KIND_CMD : KIND_PAY;
          res.item_value    = data_byte;
          res.byte_position = 9'(count_r);
          count_nxt         = count_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      esc_r    <= 1'b0;
      ovf_r    <= 1'b0;
      count_r  <= '0;
    end else if (accept) begin
      inside_r <= inside_nxt;
      esc_r    <= esc_nxt;
      ovf_r    <= ovf_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/kiss_dfr_obuf.sv
// ----------------------------------------------------------------------------
// kiss_dfr_obuf
// Two-entry output buffer: result register plus skid register, so the
// upstream stall comes straight from a flop.
// ----------------------------------------------------------------------------
module kiss_dfr_obuf import kiss_dfr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kiss_dfr_res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output kiss_dfr_res_t out_data
);

  logic          main_vld_r, main_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  kiss_dfr_res_t main_r,     main_nxt;
  kiss_dfr_res_t skid_r,     skid_nxt;
  logic          pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // no push possible while the skid entry is held
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
